// ===== hdl/pqm_pkg.sv =====
// ----------------------------------------------------------------------------
// pqm_pkg
// Shared sizes for the paired quicksort matching block.
// ----------------------------------------------------------------------------
package pqm_pkg;
	localparam int DEPTH      = 64;
	localparam int VALUE_BITS = 16;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int POS_W      = IDX_W + 2;
endpackage

// ===== hdl/paired_quicksort_match_top.sv =====
// A set of N pairs loads at one pair per cycle while in_valid is high; sorting then walks
// the lock and key memories range by range (pivot read, scans, swaps, key split, key
// write-back), then each result is read in S_ERD and registered in S_ELD, which waits while a result is stalled.
// Throughput is set by the single read and write port of each memory.
// Reset (arst_n low, asynchronous) clears count, overflow, stack pointer, out_valid and FSM;
// memories are not cleared.
// ----------------------------------------------------------------------------
// paired_quicksort_match_top
// Loads lock/key pairs, sorts locks with a Hoare partition and splits keys
// three ways around each pivot, then streams the sorted pairs.
// ----------------------------------------------------------------------------
module paired_quicksort_match_top
	import pqm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [VALUE_BITS-1:0] lock_value,
	input  logic [VALUE_BITS-1:0] key_value,
	input  logic                  last,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [VALUE_BITS-1:0] sorted_lock,
	output logic [VALUE_BITS-1:0] sorted_key,
	output logic                  last_out,
	output logic                  overflow
);
	localparam logic [3:0] S_LOAD = 4'd0, S_POP = 4'd1, S_POPW = 4'd2, S_PIV = 4'd3,
		S_SCANI = 4'd4, S_SCANJ = 4'd5, S_SWAP1 = 4'd6, S_SWAP2 = 4'd7,
		S_KA = 4'd8, S_KB = 4'd9, S_KR = 4'd10, S_KW = 4'd11,
		S_PUSH1 = 4'd12, S_PUSH2 = 4'd13, S_ERD = 4'd14, S_ELD = 4'd15;
	localparam logic [1:0] G_SMALL = 2'd0, G_EQUAL = 2'd1, G_BIG = 2'd2;

	logic [VALUE_BITS-1:0] lock_mem [DEPTH];
	logic [VALUE_BITS-1:0] key_mem [DEPTH];
	logic [VALUE_BITS-1:0] small_mem [DEPTH];
	logic [VALUE_BITS-1:0] equal_mem [DEPTH];
	logic [VALUE_BITS-1:0] scratch_mem [DEPTH];
	logic [2*IDX_W-1:0]    stack_mem [DEPTH];

	logic [3:0]            st_q;
	logic [CNT_W-1:0]      cnt_q, sp_q, k_q, ns_q, ne_q, nb_q;
	logic                  ovf_q;
	logic [IDX_W-1:0]      lo_q, hi_q, p_q;
	logic signed [POS_W-1:0] i_q, j_q;
	logic [VALUE_BITS-1:0] piv_q, ai_q;
	logic [1:0]            sel_q;

	logic [IDX_W-1:0]      lock_ra, key_ra, small_ra, equal_ra, scr_ra, stk_ra;
	logic [VALUE_BITS-1:0] lock_rd, key_rd, small_rd, equal_rd, scr_rd;
	logic [2*IDX_W-1:0]    stk_rd;
	logic                  lock_we, key_we, small_we, equal_we, scr_we, stk_we;
	logic [IDX_W-1:0]      lock_wa, key_wa, small_wa, equal_wa, scr_wa, stk_wa;
	logic [VALUE_BITS-1:0] lock_wd, key_wd;
	logic [2*IDX_W-1:0]    stk_wd;

	logic                  in_acc;
	logic [CNT_W-1:0]      cnt_new;
	logic [IDX_W:0]        mid_sum;
	logic signed [POS_W-1:0] lo_s, hi_s, i_nx, j_nx;
	logic                  i_adv, j_adv;

	assign in_ready = (st_q == S_LOAD);
	assign in_acc   = in_valid && in_ready;
	assign cnt_new  = (cnt_q < CNT_W'(DEPTH)) ? cnt_q + 1'b1 : cnt_q;
	assign mid_sum  = ({1'b0, stk_rd[2*IDX_W-1:IDX_W]} + {1'b0, stk_rd[IDX_W-1:0]}) >> 1;
	assign lo_s     = $signed({2'b00, lo_q});
	assign hi_s     = $signed({2'b00, hi_q});
	assign i_nx     = i_q + POS_W'(1);
	assign j_nx     = j_q - POS_W'(1);
	assign i_adv    = (lock_rd < piv_q) && (i_q < hi_s);
	assign j_adv    = (piv_q < lock_rd) && (j_q > lo_s);

	always_comb begin
		lock_ra = i_q[IDX_W-1:0];
		case (st_q)
			S_POPW:  lock_ra = mid_sum[IDX_W-1:0];
			S_SCANI: lock_ra = i_adv ? i_nx[IDX_W-1:0] : j_q[IDX_W-1:0];
			S_SCANJ: lock_ra = j_nx[IDX_W-1:0];
			S_SWAP2: lock_ra = i_nx[IDX_W-1:0];
			S_ERD, S_ELD: lock_ra = k_q[IDX_W-1:0];
			default: lock_ra = i_q[IDX_W-1:0];
		endcase
		key_ra   = k_q[IDX_W-1:0];
		small_ra = IDX_W'(ns_q - 1'b1);
		equal_ra = IDX_W'(ne_q - 1'b1);
		scr_ra   = IDX_W'(nb_q - 1'b1);
		stk_ra   = IDX_W'(sp_q - 1'b1);

		lock_we = 1'b0; lock_wa = i_q[IDX_W-1:0]; lock_wd = lock_rd;
		key_we = 1'b0;  key_wa = p_q;             key_wd = scr_rd;
		small_we = 1'b0; small_wa = ns_q[IDX_W-1:0];
		equal_we = 1'b0; equal_wa = ne_q[IDX_W-1:0];
		scr_we = 1'b0;   scr_wa = nb_q[IDX_W-1:0];
		stk_we = 1'b0;   stk_wa = sp_q[IDX_W-1:0];
		stk_wd = {i_q[IDX_W-1:0], hi_q};
		case (st_q)
			S_LOAD: begin
				lock_we = in_acc && (cnt_q < CNT_W'(DEPTH));
				lock_wa = cnt_q[IDX_W-1:0];
				lock_wd = lock_value;
				key_we  = lock_we;
				key_wa  = cnt_q[IDX_W-1:0];
				key_wd  = key_value;
				stk_we  = in_acc && last;
				stk_wa  = '0;
				stk_wd  = {{IDX_W{1'b0}}, IDX_W'(cnt_new - 1'b1)};
			end
			S_SCANJ: begin
				lock_we = !j_adv && (i_q <= j_q);
			end
			S_SWAP2: begin
				lock_we = 1'b1;
				lock_wa = j_q[IDX_W-1:0];
				lock_wd = ai_q;
			end
			S_KB: begin
				small_we = (key_rd < piv_q);
				equal_we = (key_rd == piv_q);
				scr_we   = (key_rd > piv_q);
			end
			S_KW: begin
				key_we = 1'b1;
				case (sel_q)
					G_SMALL: key_wd = small_rd;
					G_EQUAL: key_wd = equal_rd;
					default: key_wd = scr_rd;
				endcase
			end
			S_PUSH1: stk_we = (i_q < hi_s);
			S_PUSH2: begin
				stk_we = (lo_s < j_q);
				stk_wd = {lo_q, j_q[IDX_W-1:0]};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (lock_we) lock_mem[lock_wa] <= lock_wd;
		if (key_we) key_mem[key_wa] <= key_wd;
		if (small_we) small_mem[small_wa] <= key_rd;
		if (equal_we) equal_mem[equal_wa] <= key_rd;
		if (scr_we) scratch_mem[scr_wa] <= key_rd;
		if (stk_we) stack_mem[stk_wa] <= stk_wd;
		lock_rd  <= lock_mem[lock_ra];
		key_rd   <= key_mem[key_ra];
		small_rd <= small_mem[small_ra];
		equal_rd <= equal_mem[equal_ra];
		scr_rd   <= scratch_mem[scr_ra];
		stk_rd   <= stack_mem[stk_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_LOAD;
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
			sp_q      <= '0;
			out_valid <= 1'b0;
		end else begin
			// S_ELD reloads the output register itself when the transaction is taken
			if (out_valid && out_ready && (st_q != S_ELD)) out_valid <= 1'b0;
			unique case (st_q)
				S_LOAD: if (in_acc) begin
					cnt_q <= cnt_new;
					if (cnt_q == CNT_W'(DEPTH)) ovf_q <= 1'b1;
					if (last) begin
						sp_q <= CNT_W'(1);
						st_q <= S_POP;
					end
				end
				S_POP: begin
					if (sp_q == '0) begin
						k_q  <= '0;
						st_q <= S_ERD;
					end else begin
						sp_q <= sp_q - 1'b1;
						st_q <= S_POPW;
					end
				end
				S_POPW: begin
					lo_q <= stk_rd[2*IDX_W-1:IDX_W];
					hi_q <= stk_rd[IDX_W-1:0];
					i_q  <= $signed({2'b00, stk_rd[2*IDX_W-1:IDX_W]});
					j_q  <= $signed({2'b00, stk_rd[IDX_W-1:0]});
					st_q <= S_PIV;
				end
				S_PIV: begin
					piv_q <= lock_rd;
					st_q  <= S_SCANI;
				end
				S_SCANI: begin
					if (i_adv) i_q <= i_nx;
					else begin
						ai_q <= lock_rd;
						st_q <= S_SCANJ;
					end
				end
				S_SCANJ: begin
					if (j_adv) j_q <= j_nx;
					else if (i_q <= j_q) st_q <= S_SWAP2;
					else begin
						k_q  <= {1'b0, lo_q};
						ns_q <= '0; ne_q <= '0; nb_q <= '0;
						st_q <= S_KA;
					end
				end
				S_SWAP1: st_q <= S_SWAP2;
				S_SWAP2: begin
					i_q <= i_nx;
					j_q <= j_nx;
					if (i_nx <= j_nx) st_q <= S_SCANI;
					else begin
						k_q  <= {1'b0, lo_q};
						ns_q <= '0; ne_q <= '0; nb_q <= '0;
						st_q <= S_KA;
					end
				end
				S_KA: begin
					if (k_q > {1'b0, hi_q}) begin
						p_q  <= lo_q;
						st_q <= S_KR;
					end else st_q <= S_KB;
				end
				S_KB: begin
					if (key_rd < piv_q) ns_q <= ns_q + 1'b1;
					else if (key_rd == piv_q) ne_q <= ne_q + 1'b1;
					else nb_q <= nb_q + 1'b1;
					k_q  <= k_q + 1'b1;
					st_q <= S_KA;
				end
				S_KR: begin
					// drain groups from their ends: small, then equal, then greater
					if (ns_q != '0) begin
						sel_q <= G_SMALL; st_q <= S_KW;
					end else if (ne_q != '0) begin
						sel_q <= G_EQUAL; st_q <= S_KW;
					end else if (nb_q != '0) begin
						sel_q <= G_BIG; st_q <= S_KW;
					end else st_q <= S_PUSH1;
				end
				S_KW: begin
					p_q <= p_q + 1'b1;
					case (sel_q)
						G_SMALL: ns_q <= ns_q - 1'b1;
						G_EQUAL: ne_q <= ne_q - 1'b1;
						default: nb_q <= nb_q - 1'b1;
					endcase
					st_q <= S_KR;
				end
				S_PUSH1: begin
					if (i_q < hi_s) sp_q <= sp_q + 1'b1;
					st_q <= S_PUSH2;
				end
				S_PUSH2: begin
					if (lo_s < j_q) sp_q <= sp_q + 1'b1;
					st_q <= S_POP;
				end
				S_ERD: st_q <= S_ELD;
				S_ELD: if (!out_valid || out_ready) begin
					out_valid   <= 1'b1;
					sorted_lock <= lock_rd;
					sorted_key  <= key_rd;
					overflow    <= ovf_q;
					last_out    <= (k_q == cnt_q - 1'b1);
					if (k_q == cnt_q - 1'b1) begin
						cnt_q <= '0;
						ovf_q <= 1'b0;
						st_q  <= S_LOAD;
					end else begin
						k_q  <= k_q + 1'b1;
						st_q <= S_ERD;
					end
				end
				default: st_q <= S_LOAD;
			endcase
		end
	end
endmodule

// ===== hdl/pqm_checker.sv =====
// ----------------------------------------------------------------------------
// pqm_checker
// Port-level checks for paired_quicksort_match_top.
// ----------------------------------------------------------------------------
module pqm_checker
	import pqm_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  last,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [VALUE_BITS-1:0] sorted_lock,
	input logic                  last_out,
	input logic                  overflow
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sorted_lock))
		else $error("stalled result changed");
	a_sort_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last |=> !in_ready)
		else $error("input taken after last transaction");
	a_no_load_mid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_out |-> !in_ready)
		else $error("input open while a set is emitting");
	a_ovf_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_out ##1 out_valid |-> $stable(overflow))
		else $error("overflow changed inside a set");
endmodule

bind paired_quicksort_match_top pqm_checker u_pqm_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready), .last(last),
	.out_valid(out_valid), .out_ready(out_ready), .sorted_lock(sorted_lock),
	.last_out(last_out), .overflow(overflow)
);

// ===== tb/paired_quicksort_match_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// paired_quicksort_match_top_test
// Sends sets of lock/key pairs, sorts them in a local model with the same
// partition and three-way key split, and checks every streamed result pair.
// ----------------------------------------------------------------------------
module paired_quicksort_match_top_test;
	import pqm_pkg::*;

	typedef logic [VALUE_BITS-1:0] val_t;

	typedef struct packed {
		val_t lock;
		val_t key;
		logic lst;
		logic ovf;
	} pair_t;

	class match_scoreboard;
		val_t  locks[DEPTH];
		val_t  keys[DEPTH];
		int    count;
		bit    dropped;
		pair_t pending[$];
		int    errors;

		function void split_keys(int lo, int hi, val_t pivot);
			val_t less_q[$];
			val_t eq_q[$];
			val_t more_q[$];
			int p;
			for (int k = lo; k <= hi; k++) begin
				if (keys[k] < pivot)
					less_q.push_back(keys[k]);
				else if (keys[k] == pivot)
					eq_q.push_back(keys[k]);
				else
					more_q.push_back(keys[k]);
			end
			p = lo;
			for (int k = less_q.size() - 1; k >= 0; k--) begin
				keys[p] = less_q[k];
				p++;
			end
			for (int k = eq_q.size() - 1; k >= 0; k--) begin
				keys[p] = eq_q[k];
				p++;
			end
			for (int k = more_q.size() - 1; k >= 0; k--) begin
				keys[p] = more_q[k];
				p++;
			end
		endfunction

		function void sort_set();
			int lo_s[$];
			int hi_s[$];
			int lo, hi, i, j;
			val_t pivot, t;
			if (count < 1)
				return;
			lo_s.push_back(0);
			hi_s.push_back(count - 1);
			while (lo_s.size() > 0) begin
				lo = lo_s.pop_back();
				hi = hi_s.pop_back();
				i = lo;
				j = hi;
				pivot = locks[(lo + hi) / 2];
				do begin
					while (locks[i] < pivot && i < hi)
						i++;
					while (pivot < locks[j] && j > lo)
						j--;
					if (i <= j) begin
						t = locks[i];
						locks[i] = locks[j];
						locks[j] = t;
						i++;
						j--;
					end
				end while (i <= j);
				split_keys(lo, hi, pivot);
				if (i < hi) begin
					lo_s.push_back(i);
					hi_s.push_back(hi);
				end
				if (lo < j) begin
					lo_s.push_back(lo);
					hi_s.push_back(j);
				end
			end
		endfunction

		function void note_input(val_t lock, val_t key, logic lst);
			pair_t r;
			if (count < DEPTH) begin
				locks[count] = lock;
				keys[count] = key;
				count++;
			end else
				dropped = 1;
			if (!lst)
				return;
			sort_set();
			for (int k = 0; k < count; k++) begin
				r.lock = locks[k];
				r.key = keys[k];
				r.lst = (k + 1 == count);
				r.ovf = dropped;
				pending.push_back(r);
			end
			count = 0;
			dropped = 0;
		endfunction

		function void check_result(pair_t got);
			pair_t exp_r;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result actual %h", $time, got);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			if (got.lock !== exp_r.lock) begin
				$display("%0t: sorted_lock expected %h actual %h", $time, exp_r.lock, got.lock);
				errors++;
			end
			if (got.key !== exp_r.key) begin
				$display("%0t: sorted_key expected %h actual %h", $time, exp_r.key, got.key);
				errors++;
			end
			if (got.lst !== exp_r.lst) begin
				$display("%0t: last_out expected %b actual %b", $time, exp_r.lst, got.lst);
				errors++;
			end
			if (got.ovf !== exp_r.ovf) begin
				$display("%0t: overflow expected %b actual %b", $time, exp_r.ovf, got.ovf);
				errors++;
			end
		endfunction
	endclass

	localparam int WATCHDOG_LIMIT = 200000;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	val_t lock_value = '0;
	val_t key_value = '0;
	logic last = 0;
	logic out_valid;
	logic out_ready = 0;
	val_t sorted_lock;
	val_t sorted_key;
	logic last_out;
	logic overflow;

	match_scoreboard board;
	int idle_cycles = 0;
	int burst_left = 0;
	int stall_mode = 0;

	paired_quicksort_match_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.lock_value(lock_value), .key_value(key_value), .last(last),
		.out_valid(out_valid), .out_ready(out_ready),
		.sorted_lock(sorted_lock), .sorted_key(sorted_key),
		.last_out(last_out), .overflow(overflow)
	);

	always #5 clk = ~clk;

	// Check results and count idle cycles.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				board.check_result({sorted_lock, sorted_key, last_out, overflow});
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("paired_quicksort_match_top regression: fail");
				$finish;
			end
		end
	end

	// Receiver stall pattern: phases of always ready, random, and mostly stalled.
	always @(posedge clk) begin
		if ($urandom_range(0, 199) == 0)
			stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 1) == 1);
			default: out_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	task automatic send_pair(val_t lock, val_t key, logic lst);
		int gap;
		// Sender gaps come between bursts only; hold valid high inside a burst.
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		in_valid <= 1;
		lock_value <= lock;
		key_value <= key;
		last <= lst;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		board.note_input(lock, key, lst);
	endtask

	task automatic send_set(int n, int value_max, bit permute);
		val_t lk[$];
		val_t ky[$];
		val_t v;
		for (int k = 0; k < n; k++) begin
			v = val_t'($urandom_range(0, value_max));
			lk.push_back(v);
			ky.push_back(permute ? v : val_t'($urandom_range(0, value_max)));
		end
		if (permute)
			ky.shuffle();
		for (int k = 0; k < n; k++)
			send_pair(lk[k], ky[k], k == n - 1);
	endtask

	initial begin
		int n;
		int sel;
		int sent;
		board = new();
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: single pair, extremes, duplicates, sorted, reversed.
		send_pair('0, '1, 1'b1);
		send_pair('1, '1, 1'b0);
		send_pair('0, '0, 1'b1);
		send_pair(16'h5555, 16'haaaa, 1'b0);
		send_pair(16'haaaa, 16'h5555, 1'b0);
		send_pair(16'h7, 16'h7, 1'b0);
		send_pair(16'h7, 16'h7, 1'b1);
		for (int k = 0; k < 6; k++)
			send_pair(val_t'(k), val_t'(5 - k), k == 5);
		for (int k = 0; k < 6; k++)
			send_pair(val_t'(16'hffff - k), val_t'(16'hffff - k), k == 5);

		// Random sets: mostly small permutations, some mismatched keys, some full and overflowing sets.
		sent = 0;
		while (sent < 450) begin
			sel = $urandom_range(0, 19);
			if (sel == 0)
				n = DEPTH + $urandom_range(1, 5);
			else if (sel == 1)
				n = DEPTH;
			else
				n = $urandom_range(1, 12);
			send_set(n, ($urandom_range(0, 2) == 0) ? 7 : 16'hffff,
				$urandom_range(0, 3) != 0);
			sent += n;
		end
		in_valid <= 0;

		while (board.pending.size() > 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (board.errors == 0)
			$display("paired_quicksort_match_top regression: pass");
		else
			$display("paired_quicksort_match_top regression: fail");
		$finish;
	end
endmodule

// ===== paired_quicksort_match_top.f =====
hdl/pqm_pkg.sv
hdl/paired_quicksort_match_top.sv
hdl/pqm_checker.sv
tb/paired_quicksort_match_top_test.sv
